[sv/quoted_token_scanner_macros.svh]
// ----------------------------------------------------------------------------
// quoted token scanner assertion macros
// concurrent checks used by the scanner top level
// ----------------------------------------------------------------------------
`ifndef QUOTED_TOKEN_SCANNER_MACROS_SVH
`define QUOTED_TOKEN_SCANNER_MACROS_SVH

// same-cycle implication
`define QTS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("quoted token scanner: check failed");

// next-cycle implication
`define QTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("quoted token scanner: check failed");

`endif

[sv/qts_pkg.sv]
// ----------------------------------------------------------------------------
// qts_pkg
// types, codes and scanning functions of the quoted token scanner
// ----------------------------------------------------------------------------
`default_nettype none

package qts_pkg;

   // register indexes
   localparam logic CSR_FORCE_UPPER = 1'b0;
   localparam logic CSR_ESC_OUTSIDE = 1'b1;

   // token status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_NONE = 2'd1;
   localparam logic [1:0] ST_OPEN = 2'd2;

   // characters
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_ESC    = 8'h1B;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_E  = 8'h65;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_Z  = 8'h7A;
   localparam logic [7:0] CASE_DIFF = 8'h20;

   // result queue
   localparam int QDEPTH = 4;
   localparam int QIDX_W = $clog2(QDEPTH);
   localparam int QCNT_W = QIDX_W + 1;

   typedef enum logic [1:0] {
      Q_NONE   = 2'd0,
      Q_SINGLE = 2'd1,
      Q_DOUBLE = 2'd2
   } quote_type;

   typedef struct packed {
      quote_type open_quote;
      logic      escape_pending;
      logic      escape_cr_pending;
      logic      inside_token;
   } scan_state_type;

   localparam scan_state_type STATE_IDLE = '{Q_NONE, 1'b0, 1'b0, 1'b0};

   typedef struct packed {
      logic [7:0] out_char;
      logic       token_end;
      logic [1:0] token_status;
      logic       last;
   } res_type;

   // results of one request towards the queue
   typedef struct packed {
      logic [1:0] n;
      res_type    r0;
      res_type    r1;
   } push_type;

   typedef struct packed {
      scan_state_type st;
      logic           vld;
      res_type        res;
   } plain_type;

   function automatic res_type char_res(logic [7:0] c);
      res_type r;
      r.out_char     = c;
      r.token_end    = 1'b0;
      r.token_status = ST_OK;
      r.last         = 1'b0;
      return r;
   endfunction

   function automatic res_type end_res(logic [1:0] st);
      res_type r;
      r.out_char     = CH_NUL;
      r.token_end    = 1'b1;
      r.token_status = st;
      r.last         = 1'b0;
      return r;
   endfunction

   function automatic logic [1:0] finish_status(scan_state_type s);
      logic [1:0] st;
      if (!s.inside_token) begin
         st = ST_NONE;
      end else if (s.open_quote != Q_NONE) begin
         st = ST_OPEN;
      end else begin
         st = ST_OK;
      end
      return st;
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   // handling of a byte with no escape in progress
   function automatic plain_type plain_f(scan_state_type s, logic [7:0] c,
                                         logic upcase, logic esc_out);
      plain_type p;
      quote_type qc;
      p.st  = s;
      p.vld = 1'b0;
      p.res = char_res(c);
      if (c == CH_SQUOTE) begin
         qc = Q_SINGLE;
      end else begin
         qc = Q_DOUBLE;
      end
      if ((c == CH_NUL) || (c == CH_LF)) begin
         p.st  = STATE_IDLE;
         p.vld = 1'b1;
         p.res = end_res(finish_status(s));
      end else if ((c == CH_SQUOTE) || (c == CH_DQUOTE)) begin
         if (s.open_quote == Q_NONE) begin
            p.st.open_quote   = qc;
            p.st.inside_token = 1'b1;
         end else if (s.open_quote == qc) begin
            p.st.open_quote = Q_NONE;
         end else begin
            p.vld = 1'b1;
         end
      end else if ((c == CH_BSLASH) && ((s.open_quote == Q_DOUBLE) ||
                   ((s.open_quote == Q_NONE) && esc_out))) begin
         p.st.inside_token   = 1'b1;
         p.st.escape_pending = 1'b1;
      end else if ((s.open_quote == Q_NONE) && is_space(c)) begin
         if (s.inside_token) begin
            p.st.inside_token = 1'b0;
            p.vld             = 1'b1;
            p.res             = end_res(ST_OK);
         end
      end else begin
         p.st.inside_token = 1'b1;
         p.vld             = 1'b1;
         if (upcase && (c >= CH_LOW_A) && (c <= CH_LOW_Z)) begin
            p.res = char_res(c - CASE_DIFF);
         end
      end
      return p;
   endfunction

   function automatic logic [7:0] escape_map(logic [7:0] c);
      logic [7:0] m;
      unique case (c)
         CH_LOW_T: m = CH_TAB;
         CH_LOW_N: m = CH_LF;
         CH_LOW_R: m = CH_CR;
         CH_LOW_E: m = CH_ESC;
         default:  m = c;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

[sv/qts_req_if.sv]
// ----------------------------------------------------------------------------
// qts_req_if
// request channel carrying one text byte
// ----------------------------------------------------------------------------
`default_nettype none

interface qts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;

   modport source (output valid, output in_char, input ready);
   modport sink   (input valid, input in_char, output ready);
endinterface

`default_nettype wire

[sv/qts_rsp_if.sv]
// ----------------------------------------------------------------------------
// qts_rsp_if
// result channel carrying token characters and end markers
// ----------------------------------------------------------------------------
`default_nettype none

interface qts_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       token_end;
   logic [1:0] token_status;
   logic       last;

   modport source (output valid, output out_char, output token_end,
                   output token_status, output last, input ready);
   modport sink   (input valid, input out_char, input token_end,
                   input token_status, input last, output ready);
endinterface

`default_nettype wire

[sv/qts_step.sv]
// ----------------------------------------------------------------------------
// qts_step
// scanner state and per-byte decode into zero, one or two results
// ----------------------------------------------------------------------------
`default_nettype none

module qts_step (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             fire,
   input  wire logic [7:0]       in_char,
   input  wire logic             force_upper_case,
   input  wire logic             escape_outside_quotes,
   output qts_pkg::push_type     push
);
   import qts_pkg::*;

   scan_state_type state_ff;
   scan_state_type state_in;
   scan_state_type state_pl;
   scan_state_type state_nx;
   plain_type      pl;
   push_type       res;

   always_comb begin
      // plain handling always sees the escape flags clear
      state_pl                   = state_ff;
      state_pl.escape_pending    = 1'b0;
      state_pl.escape_cr_pending = 1'b0;
      pl = plain_f(state_pl, in_char, force_upper_case, escape_outside_quotes);

      state_nx = pl.st;
      res.n    = {1'b0, pl.vld};
      res.r0   = pl.res;
      res.r1   = pl.res;
      if (state_ff.escape_cr_pending) begin
         if (in_char == CH_LF) begin
            state_nx = STATE_IDLE;
            res.n    = 2'd1;
            res.r0   = end_res(finish_status(state_ff));
         end else begin
            // held back carriage return goes out ahead of this byte
            res.r0 = char_res(CH_CR);
            res.n  = pl.vld ? 2'd2 : 2'd1;
         end
      end else if (state_ff.escape_pending) begin
         if ((in_char == CH_NUL) || (in_char == CH_LF)) begin
            state_nx = STATE_IDLE;
            res.n    = 2'd1;
            res.r0   = end_res(finish_status(state_ff));
         end else if (in_char == CH_CR) begin
            state_nx                   = state_pl;
            state_nx.escape_cr_pending = 1'b1;
            res.n                      = 2'd0;
         end else begin
            state_nx = state_pl;
            res.n    = 2'd1;
            res.r0   = char_res(escape_map(in_char));
         end
      end
      res.r0.last = (res.n == 2'd1);
      res.r1.last = 1'b1;
   end

   always_comb begin
      push = res;
      if (!fire) begin
         push.n = 2'd0;
      end
   end

   assign state_in = fire ? state_nx : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[sv/qts_queue.sv]
// ----------------------------------------------------------------------------
// qts_queue
// small result queue taking up to two entries per cycle, draining one
// ----------------------------------------------------------------------------
`default_nettype none

module qts_queue (
   input  wire logic         clock,
   input  wire logic         reset,
   input  qts_pkg::push_type push,
   output logic              room,
   qts_rsp_if.source         rsp
);
   import qts_pkg::*;

   res_type             mem_ff [QDEPTH];
   logic [QIDX_W-1:0]   wr_ptr_ff;
   logic [QIDX_W-1:0]   wr_ptr_in;
   logic [QIDX_W-1:0]   wr_ptr_nx;
   logic [QIDX_W-1:0]   rd_ptr_ff;
   logic [QIDX_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                pop;
   res_type             head;

   assign wr_ptr_nx = wr_ptr_ff + 1'b1;
   assign head      = mem_ff[rd_ptr_ff];

   assign rsp.valid        = (count_ff != '0);
   assign rsp.out_char     = head.out_char;
   assign rsp.token_end    = head.token_end;
   assign rsp.token_status = head.token_status;
   assign rsp.last         = head.last;

   assign pop  = rsp.valid && rsp.ready;
   // space for the worst case of two results
   assign room = (count_ff <= QCNT_W'(QDEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + QIDX_W'(push.n);
   assign rd_ptr_in = rd_ptr_ff + QIDX_W'(pop);
   assign count_in  = count_ff + QCNT_W'(push.n) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push.n != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.r0;
      end
      if (push.n == 2'd2) begin
         mem_ff[wr_ptr_nx] <= push.r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[sv/quoted_token_scanner.sv]
// Path: a request is captured in the input register on acceptance, decoded once
// the result queue has room, and its first result is then offered from the queue.
// Throughput: one request per cycle while the queue has room; a request giving two
// results (an escaped carriage return followed by another byte) is drained one
// result at a time by the single-result read port of the four-entry result queue.
// Reset: synchronous, active high; clears scanner state, config and queue.
// ----------------------------------------------------------------------------
// quoted_token_scanner
// quote and escape aware tokenizer, one text byte per request
// ----------------------------------------------------------------------------
`default_nettype none
`include "quoted_token_scanner_macros.svh"

module quoted_token_scanner (
   input  wire logic   clock,
   input  wire logic   reset,
   qts_req_if.sink     req_chan,
   qts_rsp_if.source   rsp_chan,
   input  wire logic   csr_write_en,
   input  wire logic   csr_index,
   input  wire logic   csr_wdata
);
   import qts_pkg::*;

   logic       force_upper_ff;
   logic       force_upper_in;
   logic       esc_outside_ff;
   logic       esc_outside_in;
   logic       in_vld_ff;
   logic       in_vld_in;
   logic [7:0] in_char_ff;
   logic [7:0] in_char_in;
   logic       room;
   logic       fire;
   logic       accept;
   push_type   push;

   // configuration writes
   assign force_upper_in = (csr_write_en && (csr_index == CSR_FORCE_UPPER)) ?
                           csr_wdata : force_upper_ff;
   assign esc_outside_in = (csr_write_en && (csr_index == CSR_ESC_OUTSIDE)) ?
                           csr_wdata : esc_outside_ff;

   // input register
   assign fire           = in_vld_ff && room;
   assign req_chan.ready = !in_vld_ff || fire;
   assign accept         = req_chan.valid && req_chan.ready;
   assign in_vld_in      = accept || (in_vld_ff && !fire);
   assign in_char_in     = accept ? req_chan.in_char : in_char_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         force_upper_ff <= 1'b0;
         esc_outside_ff <= 1'b0;
         in_vld_ff      <= 1'b0;
      end else begin
         force_upper_ff <= force_upper_in;
         esc_outside_ff <= esc_outside_in;
         in_vld_ff      <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff <= in_char_in;
   end

   qts_step u_step (
      .clock                 (clock),
      .reset                 (reset),
      .fire                  (fire),
      .in_char               (in_char_ff),
      .force_upper_case      (force_upper_ff),
      .escape_outside_quotes (esc_outside_ff),
      .push                  (push)
   );

   qts_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .room  (room),
      .rsp   (rsp_chan)
   );

   `QTS_ASSERT_NEXT(a_accept_loads, clock, reset, accept, in_vld_ff)
   `QTS_ASSERT_NEXT(a_stall_holds, clock, reset, in_vld_ff && !fire,
      in_vld_ff && $stable(in_char_ff))
   `QTS_ASSERT_IMPLY(a_pair_starts_cr, clock, reset, push.n == 2'd2,
      (push.r0.out_char == CH_CR) && !push.r0.token_end && !push.r0.last)
   `QTS_ASSERT_IMPLY(a_push_needs_fire, clock, reset, push.n != 2'd0, fire)

endmodule

`default_nettype wire
